// ===== hdl/bihs_pkg.sv =====
// Shared types and constants for the burner ignition and hold sequencer.
package bihs_pkg;

    // Field widths
    localparam int TEMP_W   = 12;
    localparam int THRESH_W = 11;
    localparam int HOLD_W   = 22;
    localparam int IGN_W    = 16;

    // Saturation limits of the elapsed counters
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
    localparam logic [IGN_W-1:0]  IGN_MAX  = {IGN_W{1'b1}};

    // Register reset values
    localparam logic [THRESH_W-1:0] TARGET_TEMP_RST     = 11'd800;
    localparam logic [THRESH_W-1:0] MIN_TEMP_RST        = 11'd760;
    localparam logic [HOLD_W-1:0]   HOLD_DURATION_RST   = 22'd600000;
    localparam logic [IGN_W-1:0]    GAS_DELAY_RST       = 16'd3000;
    localparam logic [IGN_W-1:0]    IGNITER_TIMEOUT_RST = 16'd10000;

    // Register indexes (word address = byte address / 4)
    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_TEMP     = 3'd0,
        REG_MIN_TEMP        = 3'd1,
        REG_HOLD_DURATION   = 3'd2,
        REG_GAS_DELAY       = 3'd3,
        REG_IGNITER_TIMEOUT = 3'd4
    } reg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic [THRESH_W-1:0] target_temp;
        logic [THRESH_W-1:0] min_temp;
        logic [HOLD_W-1:0]   hold_duration;
        logic [IGN_W-1:0]    gas_delay;
        logic [IGN_W-1:0]    igniter_timeout;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              sample_valid;
        logic              sample_strobe;
        logic              stop_request;
        logic              start_request;
    } item_t;

    // One result item
    typedef struct packed {
        logic              sensor_error;
        logic              cycle_done;
        logic [HOLD_W-1:0] remaining_ms;
        logic              hold_running;
        logic              system_active;
        logic              gas_on;
        logic              igniter_on;
    } result_t;

endpackage

// ===== hdl/bihs_cfg.sv =====
// APB configuration register file for the burner sequencer.
module bihs_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bihs_pkg::cfg_t      cfg
);

    bihs_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [bihs_pkg::REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_temp     <= bihs_pkg::TARGET_TEMP_RST;
            cfg_reg.min_temp        <= bihs_pkg::MIN_TEMP_RST;
            cfg_reg.hold_duration   <= bihs_pkg::HOLD_DURATION_RST;
            cfg_reg.gas_delay       <= bihs_pkg::GAS_DELAY_RST;
            cfg_reg.igniter_timeout <= bihs_pkg::IGNITER_TIMEOUT_RST;
        end else if (wr_en) begin
            case (idx)
                bihs_pkg::REG_TARGET_TEMP:
                    cfg_reg.target_temp <= pwdata[bihs_pkg::THRESH_W-1:0];
                bihs_pkg::REG_MIN_TEMP:
                    cfg_reg.min_temp <= pwdata[bihs_pkg::THRESH_W-1:0];
                bihs_pkg::REG_HOLD_DURATION:
                    cfg_reg.hold_duration <= pwdata[bihs_pkg::HOLD_W-1:0];
                bihs_pkg::REG_GAS_DELAY:
                    cfg_reg.gas_delay <= pwdata[bihs_pkg::IGN_W-1:0];
                bihs_pkg::REG_IGNITER_TIMEOUT:
                    cfg_reg.igniter_timeout <= pwdata[bihs_pkg::IGN_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero-extended
    always_comb begin
        case (idx)
            bihs_pkg::REG_TARGET_TEMP:
                prdata = {21'd0, cfg_reg.target_temp};
            bihs_pkg::REG_MIN_TEMP:
                prdata = {21'd0, cfg_reg.min_temp};
            bihs_pkg::REG_HOLD_DURATION:
                prdata = {10'd0, cfg_reg.hold_duration};
            bihs_pkg::REG_GAS_DELAY:
                prdata = {16'd0, cfg_reg.gas_delay};
            bihs_pkg::REG_IGNITER_TIMEOUT:
                prdata = {16'd0, cfg_reg.igniter_timeout};
            default:
                prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/bihs_core.sv =====
// Sequencer state registers and the per-tick update logic.
module bihs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  bihs_pkg::cfg_t    cfg,
    input  bihs_pkg::item_t   item,
    output bihs_pkg::result_t result
);

    logic active_reg, active_next;
    logic hold_reg, hold_next;
    logic warmup_reg, warmup_next;
    logic relit_reg, relit_next;
    logic igniter_reg, igniter_next;
    logic gas_reg, gas_next;
    logic [bihs_pkg::IGN_W-1:0]  ign_elapsed_reg, ign_elapsed_next;
    logic [bihs_pkg::HOLD_W-1:0] hold_elapsed_reg, hold_elapsed_next;

    logic [bihs_pkg::TEMP_W-1:0] target_ext;
    logic [bihs_pkg::TEMP_W-1:0] min_ext;
    logic at_target;
    logic below_min;
    logic done;
    logic serr;

    assign target_ext = {1'b0, cfg.target_temp};
    assign min_ext    = {1'b0, cfg.min_temp};
    assign at_target  = item.temperature >= target_ext;
    assign below_min  = item.temperature < min_ext;

    // Compute the state after one tick
    always_comb begin
        active_next       = active_reg;
        hold_next         = hold_reg;
        warmup_next       = warmup_reg;
        relit_next        = relit_reg;
        igniter_next      = igniter_reg;
        gas_next          = gas_reg;
        ign_elapsed_next  = ign_elapsed_reg;
        hold_elapsed_next = hold_elapsed_reg;
        done              = 1'b0;
        serr              = 1'b0;

        // Advance running timers, saturating
        if (hold_reg && hold_elapsed_reg != bihs_pkg::HOLD_MAX)
            hold_elapsed_next = hold_elapsed_reg + 1'b1;
        if (igniter_reg && ign_elapsed_reg != bihs_pkg::IGN_MAX)
            ign_elapsed_next = ign_elapsed_reg + 1'b1;

        // Start from idle: warm-up and ignite
        if (item.start_request && !active_next) begin
            active_next      = 1'b1;
            warmup_next      = 1'b1;
            igniter_next     = 1'b1;
            ign_elapsed_next = '0;
            gas_next         = 1'b0;
        end

        // Stop shuts everything off
        if (item.stop_request && active_next) begin
            active_next  = 1'b0;
            hold_next    = 1'b0;
            igniter_next = 1'b0;
            gas_next     = 1'b0;
            relit_next   = 1'b0;
        end

        // Sample handling
        if (item.sample_strobe) begin
            if (!item.sample_valid) begin
                serr = 1'b1;
            end else if (active_next) begin
                if (!hold_next && at_target) begin
                    hold_next         = 1'b1;
                    hold_elapsed_next = '0;
                    warmup_next       = 1'b0;
                end
                if (hold_next && hold_elapsed_next >= cfg.hold_duration) begin
                    active_next  = 1'b0;
                    hold_next    = 1'b0;
                    igniter_next = 1'b0;
                    gas_next     = 1'b0;
                    relit_next   = 1'b0;
                    done         = 1'b1;
                end
                if (!done) begin
                    if (at_target) begin
                        igniter_next = 1'b0;
                        gas_next     = 1'b0;
                        relit_next   = 1'b0;
                        warmup_next  = 1'b0;
                    end else if (below_min && !igniter_next && !relit_next
                                 && !warmup_next) begin
                        igniter_next     = 1'b1;
                        ign_elapsed_next = '0;
                        gas_next         = 1'b0;
                        relit_next       = 1'b1;
                    end
                    if (!below_min) begin
                        relit_next  = 1'b0;
                        warmup_next = 1'b0;
                    end
                end
            end
        end

        // Igniter timing: open gas after the delay, drop igniter at timeout
        if (igniter_next) begin
            if (!gas_next && ign_elapsed_next >= cfg.gas_delay)
                gas_next = 1'b1;
            if (ign_elapsed_next >= cfg.igniter_timeout)
                igniter_next = 1'b0;
        end

        // Build the result from the new state
        result.igniter_on    = igniter_next;
        result.gas_on        = gas_next;
        result.system_active = active_next;
        result.hold_running  = hold_next;
        if (hold_next && hold_elapsed_next < cfg.hold_duration)
            result.remaining_ms = cfg.hold_duration - hold_elapsed_next;
        else
            result.remaining_ms = '0;
        result.cycle_done   = done;
        result.sensor_error = serr;
    end

    // Hold state; update once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            hold_reg         <= 1'b0;
            warmup_reg       <= 1'b0;
            relit_reg        <= 1'b0;
            igniter_reg      <= 1'b0;
            gas_reg          <= 1'b0;
            ign_elapsed_reg  <= '0;
            hold_elapsed_reg <= '0;
        end else if (advance) begin
            active_reg       <= active_next;
            hold_reg         <= hold_next;
            warmup_reg       <= warmup_next;
            relit_reg        <= relit_next;
            igniter_reg      <= igniter_next;
            gas_reg          <= gas_next;
            ign_elapsed_reg  <= ign_elapsed_next;
            hold_elapsed_reg <= hold_elapsed_next;
        end
    end

endmodule

// ===== hdl/burner_ignition_hold_sequencer_top.sv =====
// Burner ignition and hold sequencer: stream ports, input and result registers.
//
// Each input item is one millisecond tick carrying start/stop requests and an
// optional temperature sample; each item yields exactly one result item with the
// igniter, gas and hold status after that tick. The block takes one item per
// clock while the result side does not stall: an accepted item lands in the
// input register, and the state update runs in one combinational pass from
// there into the result register; the sustained rate is one item per cycle,
// set by that single state-update stage. Back-pressure on the result side
// stalls the input register, which then drops s_tready. Registers sit on the APB
// port at byte addresses 0x00 target_temp, 0x04 min_temp, 0x08 hold_duration,
// 0x0C gas_delay, 0x10 igniter_timeout; write them only while no item is in flight.
module burner_ignition_hold_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_request, [1] stop_request, [2] sample_strobe, [3] sample_valid,
    // [15:4] temperature
    input  logic [15:0] s_tdata,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] igniter_on, [1] gas_on, [2] system_active, [3] hold_running,
    // [25:4] remaining_ms, [26] cycle_done, [27] sensor_error, [31:28] zero
    output logic [31:0] m_tdata,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bihs_pkg::cfg_t    cfg;
    bihs_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    bihs_pkg::result_t result;
    bihs_pkg::result_t out_item_reg;
    logic              out_valid_reg;
    logic              advance;

    // Process the held item when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bihs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bihs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= bihs_pkg::item_t'(s_tdata);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_item_reg};

endmodule

// ===== bench/bihs_checker.sv =====
// Result checker for the burner ignition and hold sequencer: predicts and compares items.
`timescale 1ns / 1ps

module bihs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          outstanding
);

    // Predicted burner state and register copy
    bihs_pkg::cfg_t                  cfg;
    logic                            active, holding, warming, relit, igniting, gas_open;
    logic [bihs_pkg::IGN_W-1:0]      ignite_ms;
    logic [bihs_pkg::HOLD_W-1:0]     hold_ms;

    bihs_pkg::result_t               expected_status[$];
    bihs_pkg::result_t               predicted, seen, wanted;
    int                              result_count;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name,
                               input logic [bihs_pkg::HOLD_W-1:0] got,
                               input logic [bihs_pkg::HOLD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_count, name, got, want));
    endtask

    // Shut off flame and clear the relight lockout
    task automatic flame_off();
        igniting = 1'b0;
        gas_open = 1'b0;
        relit    = 1'b0;
    endtask

    task automatic light_burner();
        igniting  = 1'b1;
        ignite_ms = '0;
        gas_open  = 1'b0;
    endtask

    // Advance the burner by one millisecond tick and form its status item
    task automatic burner_tick(input bihs_pkg::item_t tick,
                               output bihs_pkg::result_t status);
        logic expired;
        expired = 1'b0;

        if (holding && hold_ms != bihs_pkg::HOLD_MAX)
            hold_ms++;
        if (igniting && ignite_ms != bihs_pkg::IGN_MAX)
            ignite_ms++;

        if (tick.start_request && !active) begin
            active  = 1'b1;
            warming = 1'b1;
            light_burner();
        end

        if (tick.stop_request && active) begin
            active  = 1'b0;
            holding = 1'b0;
            flame_off();
        end

        // Temperature sample handling
        if (tick.sample_strobe && tick.sample_valid && active) begin
            if (!holding && tick.temperature >= cfg.target_temp) begin
                holding = 1'b1;
                hold_ms = '0;
                warming = 1'b0;
            end
            if (holding && hold_ms >= cfg.hold_duration) begin
                active  = 1'b0;
                holding = 1'b0;
                flame_off();
                expired = 1'b1;
            end
            // no flame control on the tick the hold expires
            if (!expired) begin
                if (tick.temperature >= cfg.target_temp) begin
                    flame_off();
                    warming = 1'b0;
                end else if (tick.temperature < cfg.min_temp && !igniting && !relit
                             && !warming) begin
                    light_burner();
                    relit = 1'b1;
                end
                if (tick.temperature >= cfg.min_temp) begin
                    relit   = 1'b0;
                    warming = 1'b0;
                end
            end
        end

        // Igniter timing: gas follows after the delay, igniter times out
        if (igniting) begin
            if (!gas_open && ignite_ms >= cfg.gas_delay)
                gas_open = 1'b1;
            if (ignite_ms >= cfg.igniter_timeout)
                igniting = 1'b0;
        end

        status.igniter_on    = igniting;
        status.gas_on        = gas_open;
        status.system_active = active;
        status.hold_running  = holding;
        status.remaining_ms  = (holding && hold_ms < cfg.hold_duration) ?
                               cfg.hold_duration - hold_ms : '0;
        status.cycle_done    = expired;
        status.sensor_error  = tick.sample_strobe && !tick.sample_valid;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.target_temp     = bihs_pkg::TARGET_TEMP_RST;
            cfg.min_temp        = bihs_pkg::MIN_TEMP_RST;
            cfg.hold_duration   = bihs_pkg::HOLD_DURATION_RST;
            cfg.gas_delay       = bihs_pkg::GAS_DELAY_RST;
            cfg.igniter_timeout = bihs_pkg::IGNITER_TIMEOUT_RST;
            active    = 1'b0;
            holding   = 1'b0;
            warming   = 1'b0;
            relit     = 1'b0;
            igniting  = 1'b0;
            gas_open  = 1'b0;
            ignite_ms = '0;
            hold_ms   = '0;
            result_count = 0;
            expected_status.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (bihs_pkg::reg_idx_t'(paddr[4:2]))
                    bihs_pkg::REG_TARGET_TEMP:
                        cfg.target_temp = pwdata[bihs_pkg::THRESH_W-1:0];
                    bihs_pkg::REG_MIN_TEMP:
                        cfg.min_temp = pwdata[bihs_pkg::THRESH_W-1:0];
                    bihs_pkg::REG_HOLD_DURATION:
                        cfg.hold_duration = pwdata[bihs_pkg::HOLD_W-1:0];
                    bihs_pkg::REG_GAS_DELAY:
                        cfg.gas_delay = pwdata[bihs_pkg::IGN_W-1:0];
                    bihs_pkg::REG_IGNITER_TIMEOUT:
                        cfg.igniter_timeout = pwdata[bihs_pkg::IGN_W-1:0];
                    default: ;
                endcase
            end

            // Predict one status item per accepted tick
            if (s_tvalid && s_tready) begin
                burner_tick(bihs_pkg::item_t'(s_tdata), predicted);
                expected_status.push_back(predicted);
            end

            // Compare each delivered status item with the oldest prediction
            if (m_tvalid && m_tready) begin
                seen = bihs_pkg::result_t'(m_tdata[$bits(bihs_pkg::result_t)-1:0]);
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_count));
                end else begin
                    wanted = expected_status.pop_front();
                    check_field("igniter_on", seen.igniter_on, wanted.igniter_on);
                    check_field("gas_on", seen.gas_on, wanted.gas_on);
                    check_field("system_active", seen.system_active, wanted.system_active);
                    check_field("hold_running", seen.hold_running, wanted.hold_running);
                    check_field("remaining_ms", seen.remaining_ms, wanted.remaining_ms);
                    check_field("cycle_done", seen.cycle_done, wanted.cycle_done);
                    check_field("sensor_error", seen.sensor_error, wanted.sensor_error);
                end
                result_count++;
            end
        end
        outstanding = expected_status.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the burner sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [0] start_request, [1] stop_request, [2] sample_strobe, [3] sample_valid,
    // [15:4] temperature
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] igniter_on, [1] gas_on, [2] system_active, [3] hold_running,
    // [25:4] remaining_ms, [26] cycle_done, [27] sensor_error, [31:28] zero
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int ticks_sent  = 0;
    int send_idle   = 0;
    int recv_idle   = 0;
    int cur_target  = 800;
    int cur_min     = 760;

    always #10 aclk = ~aclk;

    burner_ignition_hold_sequencer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bihs_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Stall the result side at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bihs_pkg::item_t mk_tick(input logic start, input logic stop,
                                                input logic strobe, input logic valid,
                                                input int temp);
        bihs_pkg::item_t t;
        t.start_request = start;
        t.stop_request  = stop;
        t.sample_strobe = strobe;
        t.sample_valid  = valid;
        t.temperature   = temp[bihs_pkg::TEMP_W-1:0];
        return t;
    endfunction

    // Random tick, with temperatures clustered around the thresholds
    function automatic bihs_pkg::item_t random_tick();
        bihs_pkg::item_t t;
        int              temp;
        case ($urandom_range(9))
            0, 1, 2: temp = cur_target + int'($urandom_range(6)) - 3;
            3, 4, 5: temp = cur_min + int'($urandom_range(6)) - 3;
            6:       temp = int'($urandom_range(cur_min));
            7:       temp = int'($urandom_range(4095, cur_target));
            default: temp = int'($urandom_range(4095));
        endcase
        if (temp < 0)
            temp = 0;
        if (temp > 4095)
            temp = 4095;
        t = mk_tick($urandom_range(99) < 6, $urandom_range(99) < 2,
                    $urandom_range(99) < 45, $urandom_range(99) < 92, temp);
        return t;
    endfunction

    // Hand one tick to the block, idling first as the current mode asks
    task automatic send_tick(input bihs_pkg::item_t tick);
        if (ticks_sent < 217) begin
            send_idle = 22;
            recv_idle = 83;
        end else if (ticks_sent < 434) begin
            send_idle = 83;
            recv_idle = 22;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    // Hold the input side until every predicted item has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input bihs_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic configure(input int target, input int min_t, input int hold,
                             input int gas, input int ign);
        wait_drained();
        write_reg(bihs_pkg::REG_TARGET_TEMP, target);
        write_reg(bihs_pkg::REG_MIN_TEMP, min_t);
        write_reg(bihs_pkg::REG_HOLD_DURATION, hold);
        write_reg(bihs_pkg::REG_GAS_DELAY, gas);
        write_reg(bihs_pkg::REG_IGNITER_TIMEOUT, ign);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        cur_target = target;
        cur_min    = min_t;
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            if ($urandom_range(199) == 0)
                wait_drained();
            send_tick(random_tick());
        end
    endtask

    task automatic run_directed();
        bihs_pkg::item_t seq[$];
        configure(400, 300, 6, 2, 5);
        seq.push_back(mk_tick(0, 0, 1, 0, 0));     // sensor fault while idle
        seq.push_back(mk_tick(0, 0, 1, 1, 4095));  // hot sample while idle
        seq.push_back(mk_tick(1, 1, 0, 0, 0));     // start and stop together
        seq.push_back(mk_tick(1, 0, 0, 0, 0));     // ignite
        seq.push_back(mk_tick(0, 0, 1, 1, 100));   // cold during warm-up: no relight
        seq.push_back(mk_tick(0, 0, 0, 0, 0));     // gas opens
        seq.push_back(mk_tick(1, 0, 0, 0, 0));     // start while running
        seq.push_back(mk_tick(0, 0, 1, 1, 300));   // reach minimum, end warm-up
        seq.push_back(mk_tick(0, 0, 0, 0, 0));     // igniter times out
        seq.push_back(mk_tick(0, 0, 1, 1, 299));   // just below minimum: relight
        seq.push_back(mk_tick(0, 0, 1, 1, 0));     // no second relight
        seq.push_back(mk_tick(0, 0, 1, 1, 400));   // target: hold starts, flame off
        seq.push_back(mk_tick(0, 0, 1, 0, 0));     // sensor fault while holding
        seq.push_back(mk_tick(0, 0, 1, 1, 200));   // relight during hold
        seq.push_back(mk_tick(0, 0, 0, 0, 0));
        seq.push_back(mk_tick(0, 0, 0, 0, 0));
        seq.push_back(mk_tick(0, 0, 0, 0, 0));
        seq.push_back(mk_tick(0, 0, 1, 1, 100));   // hold expires, relight suppressed
        seq.push_back(mk_tick(0, 0, 0, 1, 4095));  // unstrobed reading
        seq.push_back(mk_tick(0, 1, 0, 0, 0));     // stop while idle
        seq.push_back(mk_tick(1, 0, 1, 1, 4095));  // start with a hot sample
        seq.push_back(mk_tick(0, 0, 0, 0, 0));
        seq.push_back(mk_tick(0, 1, 1, 1, 0));     // stop with a sample
        seq.push_back(mk_tick(1, 0, 1, 1, 2047));
        seq.push_back(mk_tick(0, 1, 0, 0, 0));
        foreach (seq[i])
            send_tick(seq[i]);
    endtask

    initial begin
        int target;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // Extreme settings: zero timers, inverted thresholds, gas after timeout
        configure(1200, 0, 0, 0, 0);
        run_random(65);
        configure(0, 1200, 60000, 65535, 65535);
        run_random(65);
        configure(600, 500, 20, 3, 8);
        run_random(65);
        configure(800, 760, 3600000, 10, 4);
        run_random(65);
        configure(1200, 1199, 1, 0, 65535);
        run_random(65);

        // Random settings with short timers so cycles complete
        repeat (5) begin
            target = int'($urandom_range(1200, 40));
            configure(target, target - int'($urandom_range(40)), $urandom_range(40),
                      $urandom_range(12), $urandom_range(20));
            run_random(65);
        end

        wait_drained();
        repeat (6) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
